// ===== design/rtc3w_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Shared types and constants of the three-wire serial RTC master.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

	// Default largest burst length.
	localparam int MAX_BYTES_DEF = 31;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int CFG_W   = 16;

	localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] REG_SETUP       = 2'd1;
	localparam logic [1:0] REG_HOLD        = 2'd2;

	localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd20;
	localparam logic [CFG_W-1:0] SETUP_RST       = 16'd10;
	localparam logic [CFG_W-1:0] HOLD_RST        = 16'd20;

	// Request codes
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;
	localparam logic [1:0] ACT_BYTE  = 2'd3;

	localparam logic [4:0] BURST_ADDR = 5'd31;
	localparam logic [7:0] CMD_BASE   = 8'h80;

	// Request queue between front and engine
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = QAW + 1;

	typedef struct packed {
		logic [CFG_W-1:0] half_period;
		logic [CFG_W-1:0] setup;
		logic [CFG_W-1:0] hold;
	} cfg_t;

	// A classified input word.
	typedef struct packed {
		logic       start;    // start read or start write
		logic       rd;       // start read
		logic       wr_byte;  // next write byte supplied
		logic [7:0] cmd;      // command byte, read bit included
		logic [4:0] count;    // data bytes, already clamped
		logic [7:0] data;
		logic       io;
	} item_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           full;
		logic           empty;
	} q_stat_t;

	typedef struct packed {
		logic       enable_pin;
		logic       clock_pin;
		logic       data_out;
		logic       data_drive;
		logic [7:0] read_data;
		logic       read_valid;
		logic       need_byte;
		logic       done_res;
		logic       busy_res;
	} res_t;

	typedef enum logic [7:0] {
		PH_IDLE  = 8'b0000_0001,
		PH_SETUP = 8'b0000_0010,
		PH_BLOW  = 8'b0000_0100,
		PH_BHIGH = 8'b0000_1000,
		PH_WAITB = 8'b0001_0000,
		PH_RHIGH = 8'b0010_0000,
		PH_RLOW  = 8'b0100_0000,
		PH_HOLD  = 8'b1000_0000
	} phase_t;

endpackage

// ===== design/rtc3w_front.sv =====
// ----------------------------------------------------------------------------
// rtc3w_front
// Input stage: classifies each word, builds the command byte and clamps the
// byte count, then hands the word on to the request queue.
// ----------------------------------------------------------------------------
module rtc3w_front #(
	parameter int MAX_BYTES = rtc3w_pkg::MAX_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic                ram_select,
	input  logic [4:0]          reg_addr,
	input  logic [4:0]          byte_count,
	input  logic [7:0]          data_byte,
	input  logic                io_in,
	output logic                push_valid,
	output rtc3w_pkg::item_t    push_item,
	input  logic                push_ready
);
	import rtc3w_pkg::*;

	localparam logic [4:0] MAX_CNT = 5'(MAX_BYTES);

	logic       valid_s1;
	item_t      item_s1;
	item_t      dec;
	logic [4:0] n_raw;

	always_comb begin
		n_raw = (reg_addr == BURST_ADDR) ? byte_count : 5'd1;
		dec.start   = (action == ACT_READ) || (action == ACT_WRITE);
		dec.rd      = (action == ACT_READ);
		dec.wr_byte = (action == ACT_BYTE);
		dec.cmd     = CMD_BASE | {1'b0, ram_select, reg_addr, (action == ACT_READ)};
		if (n_raw == 5'd0) begin
			dec.count = 5'd1;
		end else if (n_raw > MAX_CNT) begin
			dec.count = MAX_CNT;
		end else begin
			dec.count = n_raw;
		end
		dec.data = data_byte;
		dec.io   = io_in;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= dec;
		end
	end

endmodule

// ===== design/rtc3w_queue.sv =====
// ----------------------------------------------------------------------------
// rtc3w_queue
// Short first-in first-out queue of classified words between the front and
// the bit engine.
// ----------------------------------------------------------------------------
module rtc3w_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  rtc3w_pkg::item_t    push_item,
	output logic                push_ready,
	output logic                pop_valid,
	output rtc3w_pkg::item_t    pop_item,
	input  logic                pop_ready,
	output rtc3w_pkg::q_stat_t  stat
);
	import rtc3w_pkg::*;

	item_t          slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           push;
	logic           pop;

	assign stat.count = count_q;
	assign stat.full  = (count_q == QCW'(QDEPTH));
	assign stat.empty = (count_q == '0);

	assign push_ready = !stat.full;
	assign pop_valid  = !stat.empty;
	assign pop_item   = slot_q[rd_ptr_q];

	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== design/rtc3w_engine.sv =====
// ----------------------------------------------------------------------------
// rtc3w_engine
// Bit engine: advances the transfer sequencer by one tick per word and
// registers the resulting pin levels in the output stage.
// ----------------------------------------------------------------------------
module rtc3w_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  rtc3w_pkg::cfg_t     cfg,
	input  logic                item_valid,
	input  rtc3w_pkg::item_t    item,
	output logic                item_ready,
	output logic                res_valid,
	output rtc3w_pkg::res_t     res,
	input  logic                res_ready
);
	import rtc3w_pkg::*;

	phase_t            phase_q, ph_n;
	logic [CFG_W-1:0]  tick_q, tick_n;
	logic [2:0]        bit_q, bit_n;
	logic [7:0]        shift_q, shift_n;
	logic [4:0]        left_q, left_n;
	logic              is_read_q, is_read_n;
	logic [7:0]        pend_byte_q, pend_byte_n;
	logic              pend_valid_q, pend_valid_n;

	logic              out_valid_q;
	res_t              out_q;
	res_t              res_n;

	logic [CFG_W-1:0]  lim_raw;
	logic [CFG_W-1:0]  lim_eff;
	logic [CFG_W-1:0]  tick_inc;
	logic              over;
	logic [7:0]        sampled;
	logic [4:0]        left_dec;
	logic              fire;
	logic              drive;

	assign item_ready = !out_valid_q || res_ready;
	assign fire       = item_valid && item_ready;
	assign res_valid  = out_valid_q;
	assign res        = out_q;

	// One shared tick counter; the limit follows the current phase.
	always_comb begin
		unique case (phase_q)
			PH_SETUP: lim_raw = cfg.setup;
			PH_HOLD:  lim_raw = cfg.hold;
			default:  lim_raw = cfg.half_period;
		endcase
	end

	assign lim_eff  = (lim_raw == '0) ? CFG_W'(1) : lim_raw;
	assign tick_inc = tick_q + CFG_W'(1);
	assign over     = (tick_inc >= lim_eff);
	assign sampled  = shift_q | (8'(item.io) << bit_q);
	assign left_dec = left_q - 5'd1;

	always_comb begin
		ph_n         = phase_q;
		tick_n       = tick_q;
		bit_n        = bit_q;
		shift_n      = shift_q;
		left_n       = left_q;
		is_read_n    = is_read_q;
		pend_byte_n  = pend_byte_q;
		pend_valid_n = pend_valid_q;
		res_n        = '0;

		if (phase_q == PH_IDLE) begin
			if (item.start) begin
				is_read_n    = item.rd;
				shift_n      = item.cmd;
				left_n       = item.count;
				pend_byte_n  = item.data;
				pend_valid_n = !item.rd;
				bit_n        = '0;
				tick_n       = '0;
				ph_n         = PH_SETUP;
			end
		end else begin
			// A supplied write byte is visible to the rest of this tick.
			if (item.wr_byte && !is_read_q && !pend_valid_q) begin
				pend_byte_n  = item.data;
				pend_valid_n = 1'b1;
			end
			unique case (phase_q)
				PH_SETUP, PH_BLOW, PH_RHIGH, PH_HOLD: begin
					tick_n = over ? '0 : tick_inc;
					if (over) begin
						unique case (phase_q)
							PH_SETUP: ph_n = PH_BLOW;
							PH_BLOW:  ph_n = PH_BHIGH;
							PH_RHIGH: ph_n = PH_RLOW;
							default: begin
								ph_n           = PH_IDLE;
								res_n.done_res = 1'b1;
							end
						endcase
					end
				end
				PH_BHIGH: begin
					tick_n = over ? '0 : tick_inc;
					if (over) begin
						if (bit_q != 3'd7) begin
							bit_n = bit_q + 3'd1;
							ph_n  = PH_BLOW;
						end else begin
							bit_n = '0;
							if (is_read_q) begin
								shift_n = '0;
								ph_n    = PH_RHIGH;
							end else if (left_q == '0) begin
								ph_n = PH_HOLD;
							end else if (pend_valid_n) begin
								shift_n      = pend_byte_n;
								pend_valid_n = 1'b0;
								left_n       = left_dec;
								ph_n         = PH_BLOW;
							end else begin
								ph_n = PH_WAITB;
							end
						end
					end
				end
				PH_WAITB: begin
					if (pend_valid_n) begin
						shift_n      = pend_byte_n;
						pend_valid_n = 1'b0;
						left_n       = left_dec;
						bit_n        = '0;
						tick_n       = '0;
						ph_n         = PH_BLOW;
					end
				end
				PH_RLOW: begin
					tick_n = over ? '0 : tick_inc;
					if (over) begin
						if (bit_q != 3'd7) begin
							shift_n = sampled;
							bit_n   = bit_q + 3'd1;
							ph_n    = PH_RHIGH;
						end else begin
							res_n.read_valid = 1'b1;
							res_n.read_data  = sampled;
							shift_n          = '0;
							bit_n            = '0;
							left_n           = left_dec;
							ph_n             = (left_dec != '0) ? PH_RHIGH : PH_HOLD;
						end
					end
				end
				default: begin
					ph_n   = PH_IDLE;
					tick_n = '0;
				end
			endcase
		end

		drive            = (ph_n == PH_BLOW) || (ph_n == PH_BHIGH);
		res_n.data_drive = drive;
		res_n.data_out   = drive && shift_n[bit_n];
		res_n.clock_pin  = (ph_n == PH_BHIGH) || (ph_n == PH_WAITB) || (ph_n == PH_RHIGH) ||
			((ph_n == PH_HOLD) && !is_read_n);
		res_n.enable_pin = (ph_n != PH_IDLE);
		res_n.busy_res   = (ph_n != PH_IDLE);
		res_n.need_byte  = (ph_n == PH_WAITB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_q       <= '0;
			bit_q        <= '0;
			shift_q      <= '0;
			left_q       <= '0;
			is_read_q    <= 1'b0;
			pend_byte_q  <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				phase_q      <= ph_n;
				tick_q       <= tick_n;
				bit_q        <= bit_n;
				shift_q      <= shift_n;
				left_q       <= left_n;
				is_read_q    <= is_read_n;
				pend_byte_q  <= pend_byte_n;
				pend_valid_q <= pend_valid_n;
				out_valid_q  <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res_n;
		end
	end

endmodule

// ===== design/three_wire_rtc_serial_master.sv =====
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Three-wire master for a serial real-time-clock chip with an APB-style
// register port for its timing.
// ----------------------------------------------------------------------------
// Each input word is one timing tick and yields exactly one output word with
// the pin levels after that tick. The block takes one word per clock cycle
// and keeps that rate as long as out_ready stays high; a word passes the input
// stage, the four-entry request queue and the output register, in that order.
// The sequencer in the bit engine advances once per word, which sets the
// one-word-per-cycle figure.
// Timing registers: half_period_ticks at 0x0, setup_ticks at 0x4, hold_ticks
// at 0x8; write them only while no transaction is in flight.
module three_wire_rtc_serial_master #(
	parameter int MAX_BYTES = rtc3w_pkg::MAX_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rtc3w_pkg::PADDR_W-1:0]   paddr,
	input  logic [rtc3w_pkg::PDATA_W-1:0]   pwdata,
	output logic [rtc3w_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      action,
	input  logic                            ram_select,
	input  logic [4:0]                      reg_addr,
	input  logic [4:0]                      byte_count,
	input  logic [7:0]                      data_byte,
	input  logic                            io_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            enable_pin,
	output logic                            clock_pin,
	output logic                            data_out,
	output logic                            data_drive,
	output logic [7:0]                      read_data,
	output logic                            read_valid,
	output logic                            need_byte,
	output logic                            done_res,
	output logic                            busy_res
);
	import rtc3w_pkg::*;

	logic [CFG_W-1:0] half_period_q;
	logic [CFG_W-1:0] setup_q;
	logic [CFG_W-1:0] hold_q;
	cfg_t             cfg;
	logic             cfg_wr;
	logic [1:0]       reg_idx;

	logic             push_valid;
	item_t            push_item;
	logic             push_ready;
	logic             pop_valid;
	item_t            pop_item;
	logic             pop_ready;
	q_stat_t          q_stat;
	res_t             res;

	// Register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
			setup_q       <= SETUP_RST;
			hold_q        <= HOLD_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_HALF_PERIOD: half_period_q <= pwdata[CFG_W-1:0];
				REG_SETUP:       setup_q       <= pwdata[CFG_W-1:0];
				REG_HOLD:        hold_q        <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HALF_PERIOD: prdata = PDATA_W'(half_period_q);
			REG_SETUP:       prdata = PDATA_W'(setup_q);
			REG_HOLD:        prdata = PDATA_W'(hold_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.half_period = half_period_q;
	assign cfg.setup       = setup_q;
	assign cfg.hold        = hold_q;

	rtc3w_front #(
		.MAX_BYTES (MAX_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.ram_select (ram_select),
		.reg_addr   (reg_addr),
		.byte_count (byte_count),
		.data_byte  (data_byte),
		.io_in      (io_in),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	rtc3w_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready),
		.stat       (q_stat)
	);

	rtc3w_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (pop_valid),
		.item       (pop_item),
		.item_ready (pop_ready),
		.res_valid  (out_valid),
		.res        (res),
		.res_ready  (out_ready)
	);

	assign enable_pin = res.enable_pin;
	assign clock_pin  = res.clock_pin;
	assign data_out   = res.data_out;
	assign data_drive = res.data_drive;
	assign read_data  = res.read_data;
	assign read_valid = res.read_valid;
	assign need_byte  = res.need_byte;
	assign done_res   = res.done_res;
	assign busy_res   = res.busy_res;

`ifndef ASSERT_OFF
	// The queue never holds more words than it has slots.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCW'(QDEPTH))
		else $error("request queue count exceeds its depth");

	// A received byte completes while enable is high and the line is released.
	a_read_sample: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> enable_pin && !data_drive && !need_byte)
		else $error("read byte completed with the data line driven");

	// While a write waits for data, the clock is parked high and the line is released.
	a_wait_park: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && need_byte |-> enable_pin && clock_pin && !data_drive && busy_res)
		else $error("byte wait with clock low or data driven");
`endif

endmodule
